// ----- rtl/arbm_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the audio ring buffer mixer.
// No dependencies; used by arbm_restart and audio_ring_buffer_mix.
package arbm_pkg;

	localparam int SAMPLE_W  = 16;
	localparam int FILL_W    = 10;
	localparam int DEPTH_DEF = 1024;

	// Saturation limits of the mixed sum
	localparam logic signed [SAMPLE_W:0] SAT_POS = 17'sd32767;
	localparam logic signed [SAMPLE_W:0] SAT_NEG = -17'sd32767;

	// Operation carried on the input tuser
	typedef enum logic [1:0] {
		MODE_ENQ = 2'd0,
		MODE_DEQ = 2'd1,
		MODE_MIX = 2'd2,
		MODE_NOP = 2'd3
	} mode_t;

	// Status of the restart sequencer toward the datapath
	typedef struct packed {
		logic busy;      // no words accepted
		logic clearing;  // zero the entry at the clear address
		logic load_ptr;  // reduced fill offset valid, load write pointer
	} restart_ctl_t;

endpackage

// ----- rtl/arbm_restart.sv -----
`timescale 1ns / 1ps
// Restart sequencer: sweeps the sample memory to zero one entry a cycle and
// reduces the fill offset modulo DEPTH by a reciprocal multiply. Uses arbm_pkg.
module arbm_restart #(
	parameter int DEPTH = arbm_pkg::DEPTH_DEF,
	parameter int PTR_W = $clog2(DEPTH)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [arbm_pkg::FILL_W-1:0] fill,
	output arbm_pkg::restart_ctl_t     ctl,
	output logic [PTR_W-1:0]           clr_addr,
	output logic [arbm_pkg::FILL_W-1:0] fill_mod
);
	import arbm_pkg::*;

	// quotient = (fill * RECIP) >> SHIFT is exact for every FILL_W-bit offset
	localparam int SHIFT = FILL_W + PTR_W;
	localparam int RECIP = ((1 << SHIFT) + DEPTH - 1) / DEPTH;

	logic              busy_q;
	logic              clr_done_q;
	logic [PTR_W-1:0]  clr_cnt_q;
	logic [FILL_W-1:0] fill_q;
	logic [FILL_W-1:0] quot_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b1;
			clr_done_q <= 1'b0;
			clr_cnt_q  <= '0;
			fill_q     <= '0;
			quot_q     <= '0;
		end else begin
			// quotient settles in the cycle after the offset is stored, long before the load
			quot_q <= FILL_W'((32'(fill_q) * 32'(RECIP)) >> SHIFT);
			if (start) begin
				busy_q     <= 1'b1;
				clr_done_q <= 1'b0;
				clr_cnt_q  <= '0;
				fill_q     <= fill;
			end else if (busy_q) begin
				// memory sweep, then the pointer load state
				if (!clr_done_q) begin
					if (clr_cnt_q == PTR_W'(DEPTH-1)) begin
						clr_done_q <= 1'b1;
					end else begin
						clr_cnt_q <= clr_cnt_q + 1'b1;
					end
				end else begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	assign ctl.busy     = busy_q;
	assign ctl.clearing = busy_q && !clr_done_q;
	assign ctl.load_ptr = busy_q && clr_done_q;
	assign clr_addr     = clr_cnt_q;
	assign fill_mod     = FILL_W'(32'(fill_q) - 32'(quot_q) * 32'(DEPTH));

endmodule

// ----- rtl/audio_ring_buffer_mix.sv -----
`timescale 1ns / 1ps
// Audio ring buffer with overwrite of the oldest sample and saturating mix.
// An accepted word passes the stage-1 register, then the output register, to m_*.
// Throughput: one word per cycle unless m_tready stalls or a restart is busy; the
// sample memory has one write and one read port. Reset and every initial_fill
// write zero the memory, no words taken. Depends on arbm_pkg and arbm_restart.
module audio_ring_buffer_mix #(
	parameter int DEPTH = arbm_pkg::DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration: initial_fill
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [arbm_pkg::FILL_W-1:0]   cfg_data,
	// input stream
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [arbm_pkg::SAMPLE_W-1:0] s_tdata,   // [15:0] sample_in
	input  logic [1:0]                    s_tuser,   // [1:0] mode
	input  logic                          s_tlast,   // block_end
	// output stream
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [arbm_pkg::SAMPLE_W-1:0] m_tdata,   // [15:0] sample_out
	output logic [1:0]                    m_tuser,   // [0] sample_valid, [1] dropped_oldest
	output logic                          m_tlast    // block_end_out
);
	import arbm_pkg::*;

	localparam int PTR_W = $clog2(DEPTH);

	function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH-1)) ? '0 : p + 1'b1;
	endfunction

	restart_ctl_t      rst_ctl;
	logic [PTR_W-1:0]  clr_addr;
	logic [FILL_W-1:0] fill_mod;
	logic              cfg_wr;

	logic [SAMPLE_W-1:0] mem [DEPTH];

	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [PTR_W-1:0] wr_next, rd_next;
	mode_t            mode;
	logic             accept, advance;
	logic             is_enq, is_deq, not_empty, wrap_hit;

	logic                vld_s1, deq_s1, mix_s1, drop_s1, last_s1;
	logic [SAMPLE_W-1:0] smp_s1, rdata_s1;

	logic                out_vld_q, out_val_q, out_drop_q, out_last_q;
	logic [SAMPLE_W-1:0] out_smp_q;
	logic signed [SAMPLE_W:0] sum;
	logic [SAMPLE_W-1:0]      result;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;

	arbm_restart #(
		.DEPTH(DEPTH),
		.PTR_W(PTR_W)
	) u_restart (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cfg_wr),
		.fill     (cfg_data),
		.ctl      (rst_ctl),
		.clr_addr (clr_addr),
		.fill_mod (fill_mod)
	);

	// Handshake
	assign advance  = vld_s1 && (!out_vld_q || m_tready);
	assign s_tready = !rst_ctl.busy && (!vld_s1 || advance);
	assign accept   = s_tvalid && s_tready;

	// Pointer decisions need no memory data
	assign mode      = mode_t'(s_tuser);
	assign is_enq    = (mode == MODE_ENQ);
	assign is_deq    = (mode == MODE_DEQ) || (mode == MODE_MIX);
	assign wr_next   = ring_next(wr_ptr_q);
	assign rd_next   = ring_next(rd_ptr_q);
	assign wrap_hit  = (wr_next == rd_ptr_q);
	assign not_empty = (rd_ptr_q != wr_ptr_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
		end else if (cfg_wr) begin
			rd_ptr_q <= '0;
		end else if (rst_ctl.load_ptr) begin
			wr_ptr_q <= PTR_W'(fill_mod);
		end else if (accept) begin
			if (is_enq) begin
				wr_ptr_q <= wr_next;
				if (wrap_hit) begin
					rd_ptr_q <= rd_next;
				end
			end else if (is_deq && not_empty) begin
				rd_ptr_q <= rd_next;
			end
		end
	end

	// Sample memory: clear sweep or enqueue write, registered read
	always_ff @(posedge clk) begin
		if (rst_ctl.clearing) begin
			mem[clr_addr] <= '0;
		end else if (accept && is_enq) begin
			mem[wr_ptr_q] <= s_tdata;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && is_deq) begin
			rdata_s1 <= mem[rd_ptr_q];
		end
	end

	// Stage 1: item waiting on read data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (accept) begin
			vld_s1 <= 1'b1;
		end else if (advance) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			deq_s1  <= is_deq && not_empty;
			mix_s1  <= (mode == MODE_MIX);
			drop_s1 <= is_enq && wrap_hit;
			last_s1 <= s_tlast;
			smp_s1  <= s_tdata;
		end
	end

	// Saturating mix
	assign sum = $signed({smp_s1[SAMPLE_W-1], smp_s1})
		+ $signed({rdata_s1[SAMPLE_W-1], rdata_s1});

	always_comb begin
		if (!deq_s1) begin
			result = '0;
		end else if (!mix_s1) begin
			result = rdata_s1;
		end else if (sum > SAT_POS) begin
			result = SAT_POS[SAMPLE_W-1:0];
		end else if (sum < SAT_NEG) begin
			result = SAT_NEG[SAMPLE_W-1:0];
		end else begin
			result = sum[SAMPLE_W-1:0];
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (advance) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_smp_q  <= result;
			out_val_q  <= deq_s1;
			out_drop_q <= drop_s1;
			out_last_q <= last_s1;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_smp_q;
	assign m_tuser  = {out_drop_q, out_val_q};
	assign m_tlast  = out_last_q;

endmodule
